// File: rtl/heading_lqg_motor_control_core_defines.svh
// Assertion helpers shared by the heading controller RTL.
// Both expect signals named clk and rst in the calling scope.
`ifndef HEADING_LQG_MOTOR_CONTROL_CORE_DEFINES_SVH
`define HEADING_LQG_MOTOR_CONTROL_CORE_DEFINES_SVH

// Same-cycle implication.
`define HLMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HLMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hlmc_pkg.sv
package hlmc_pkg;

  // Field and register widths
  localparam int HEAD_W     = 16;
  localparam int TGT_W      = 9;
  localparam int GAIN_W     = 24;
  localparam int PERIOD_W   = 16;
  localparam int DB_W       = 16;
  localparam int DRIVE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int S_TDATA_W  = 32;
  localparam int S_TUSER_W  = 1;
  localparam int M_TUSER_W  = 2;

  // Heading arithmetic: 1/128 degree units, error fits in 18 signed bits
  localparam int HEAD_FRAC  = 7;
  localparam int ERR_W      = 18;
  localparam int FULL_TURN  = 360;

  // Gain products are scaled back by 16 fractional bits
  localparam int GAIN_FRAC  = 16;
  localparam int CHUNK_W    = 24;
  // Width of the signed word in which saturation at full width is one short
  localparam int HOST_WORD_W = 64;

  // Effort limit and percent scaling
  localparam int U_LIMIT    = 254;
  localparam int U_LIMIT_W  = 8;
  localparam int PERCENT    = 100;
  localparam int PERCENT_W  = 7;
  localparam int PCT_W      = 15;
  // floor(p/254) == (p*33027)>>23 for every p below 33554
  localparam int DIV_RECIP  = 33027;
  localparam int RECIP_W    = 16;
  localparam int DIV_SHIFT  = 23;
  localparam int QUO_W      = 7;

  // Register reset values
  localparam logic [GAIN_W-1:0]   RST_POS_GAIN  = 24'd663289;
  localparam logic [GAIN_W-1:0]   RST_RATE_GAIN = 24'd492175;
  localparam logic [GAIN_W-1:0]   RST_OBS_EGAIN = 24'd113514;
  localparam logic [GAIN_W-1:0]   RST_OBS_RGAIN = 24'd65536;
  localparam logic [GAIN_W-1:0]   RST_INV_INERT = 24'd32768;
  localparam logic [PERIOD_W-1:0] RST_PERIOD    = 16'd1311;
  localparam logic [DB_W-1:0]     RST_DEADBAND  = 16'd64;

  // Request to the shared multiply unit
  typedef struct packed {
    logic              start;
    logic [GAIN_W-1:0] gain;
  } mul_req_t;

endpackage

// File: rtl/heading_lqg_motor_control_core.sv
// Heading hold controller with an observed error and rate. Each input item is one
// control tick (measured heading, target azimuth, track flag) and yields exactly
// one result item (drive percent, deadband flag, saturation flag). The block takes
// one item at a time: s_tready is high only while it is idle, and a finished item
// waits in the output register while the next one is accepted. A tick inside the
// deadband goes from S_ERR straight to S_OUT, with no gain products. A full tick
// runs nine gain products one after another through one shared multiply unit and
// then scales and divides the effort. Configuration writes are taken every cycle.
`include "heading_lqg_motor_control_core_defines.svh"

module heading_lqg_motor_control_core #(
  parameter int FRAC_BITS   = 16,
  parameter int STATE_WIDTH = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] measured_heading, [24:16] target_heading, [31:25] zero
  input  logic [hlmc_pkg::S_TDATA_W-1:0]      s_tdata,
  // [0] track_enable
  input  logic [hlmc_pkg::S_TUSER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] drive_percent
  output logic [hlmc_pkg::DRIVE_W-1:0]        m_tdata,
  // [0] in_deadband, [1] saturated
  output logic [hlmc_pkg::M_TUSER_W-1:0]      m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hlmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hlmc_pkg::GAIN_W-1:0]         cfg_data
);

  localparam int SW      = STATE_WIDTH;
  localparam int FB      = FRAC_BITS;
  localparam int ERR_W   = hlmc_pkg::ERR_W;
  localparam int GW      = hlmc_pkg::GAIN_W;
  localparam int EW      = ERR_W + FB - hlmc_pkg::HEAD_FRAC;
  localparam int XW      = ((EW > SW) ? EW : SW) + 1;
  localparam int UMAG_W  = FB + hlmc_pkg::U_LIMIT_W;
  localparam int PPROD_W = UMAG_W + hlmc_pkg::PERCENT_W;
  localparam int QPROD_W = hlmc_pkg::PCT_W + hlmc_pkg::RECIP_W;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [XW-1:0] XMAX = XW'(SMAX);
  localparam logic signed [XW-1:0] XMIN = XW'(SMIN);
  localparam logic signed [SW-1:0] LIM  = SW'(hlmc_pkg::U_LIMIT) << FB;
  localparam logic signed [SW-1:0] NLIM = -LIM;
  localparam logic signed [ERR_W-1:0] TURN =
    ERR_W'(hlmc_pkg::FULL_TURN) << hlmc_pkg::HEAD_FRAC;

  localparam logic [hlmc_pkg::CFG_IDX_W-1:0] CFG_POS_GAIN  = 3'd0;
  localparam logic [hlmc_pkg::CFG_IDX_W-1:0] CFG_RATE_GAIN = 3'd1;
  localparam logic [hlmc_pkg::CFG_IDX_W-1:0] CFG_OBS_EGAIN = 3'd2;
  localparam logic [hlmc_pkg::CFG_IDX_W-1:0] CFG_OBS_RGAIN = 3'd3;
  localparam logic [hlmc_pkg::CFG_IDX_W-1:0] CFG_INV_INERT = 3'd4;
  localparam logic [hlmc_pkg::CFG_IDX_W-1:0] CFG_PERIOD    = 3'd5;
  localparam logic [hlmc_pkg::CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_ISSUE,
    S_WAIT,
    S_SCALE,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_KP,
    OP_KV,
    OP_EKT,
    OP_FKT,
    OP_WT,
    OP_EINNOV,
    OP_UT,
    OP_UJ,
    OP_WINNOV
  } op_t;

  function automatic logic signed [SW-1:0] clampx(input logic signed [XW-1:0] x);
    if (x > XMAX) return SMAX;
    else if (x < XMIN) return SMIN;
    else return SW'(x);
  endfunction

  function automatic logic signed [SW-1:0] sadd(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [XW-1:0] sum;
    sum = XW'(a) + XW'(b);
    return clampx(sum);
  endfunction

  function automatic logic signed [SW-1:0] sneg(input logic signed [SW-1:0] a);
    return (a == SMIN) ? SMAX : -a;
  endfunction

  function automatic logic [ERR_W-1:0] mag_err(input logic signed [ERR_W-1:0] x);
    return x[ERR_W-1] ? ERR_W'(-x) : ERR_W'(x);
  endfunction

  state_t state;
  op_t    op;

  logic [GW-1:0]                   kp, kv, kep, kef, jinv;
  logic [hlmc_pkg::PERIOD_W-1:0]   period;
  logic [hlmc_pkg::DB_W-1:0]       deadband;

  logic [hlmc_pkg::HEAD_W-1:0]     hd_meas;
  logic [hlmc_pkg::TGT_W-1:0]      hd_tgt;
  logic                            trk;

  logic signed [SW-1:0] err_e, u_reg, tmp, newe, est_err, est_rate;
  logic [GW-1:0]        ekt, fkt;
  logic                 sat_flag;
  logic [hlmc_pkg::PCT_W-1:0]   pct;
  logic [hlmc_pkg::DRIVE_W-1:0] r_drive;
  logic                 r_db, r_sat;

  hlmc_pkg::mul_req_t   mul_req;
  logic signed [SW-1:0] mul_a;
  logic                 mul_done;
  logic signed [SW-1:0] mul_res;

  // heading error selection
  logic [ERR_W-1:0]        s_u;
  logic signed [ERR_W-1:0] e1, e2, e3, err;
  logic [ERR_W-1:0]        a1, a2, a3, err_abs;
  logic                    in_db;
  logic signed [EW-1:0]    e_wide;
  logic signed [SW-1:0]    e_sat;

  logic signed [SW-1:0]       u_sum;
  logic [UMAG_W-1:0]          umag;
  logic [PPROD_W-1:0]         pprod;
  logic [QPROD_W-1:0]         qprod;
  logic [hlmc_pkg::QUO_W-1:0] quo;
  logic                       u_pos;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    s_u = trk ? ERR_W'({hd_tgt, {hlmc_pkg::HEAD_FRAC{1'b0}}}) : ERR_W'(hd_meas);
    e1  = $signed(s_u) - $signed(ERR_W'(hd_meas));
    e2  = e1 + TURN;
    e3  = e1 - TURN;
    a1  = mag_err(e1);
    a2  = mag_err(e2);
    a3  = mag_err(e3);
    // first smallest magnitude wins on ties
    if (a1 <= a2 && a1 <= a3) err = e1;
    else if (a2 <= a1 && a2 <= a3) err = e2;
    else err = e3;
    err_abs = mag_err(err);
    in_db   = err_abs < ERR_W'(deadband);
    e_wide  = EW'(err) <<< (FB - hlmc_pkg::HEAD_FRAC);
    e_sat   = clampx(XW'(e_wide));
  end

  always_comb begin
    mul_req.start = (state == S_ISSUE);
    mul_req.gain  = '0;
    mul_a         = '0;
    case (op)
      OP_KP: begin
        mul_a         = err_e;
        mul_req.gain  = kp;
      end
      OP_KV: begin
        mul_a         = est_rate;
        mul_req.gain  = kv;
      end
      OP_EKT: begin
        mul_a         = SW'(kep);
        mul_req.gain  = GW'(period);
      end
      OP_FKT: begin
        mul_a         = SW'(kef);
        mul_req.gain  = GW'(period);
      end
      OP_WT: begin
        mul_a         = est_rate;
        mul_req.gain  = GW'(period);
      end
      OP_EINNOV: begin
        mul_a         = sadd(err_e, sneg(est_err));
        mul_req.gain  = ekt;
      end
      OP_UT: begin
        mul_a         = u_reg;
        mul_req.gain  = GW'(period);
      end
      OP_UJ: begin
        mul_a         = tmp;
        mul_req.gain  = jinv;
      end
      OP_WINNOV: begin
        mul_a         = sadd(err_e, sneg(newe));
        mul_req.gain  = fkt;
      end
      default: begin
        mul_a         = '0;
        mul_req.gain  = '0;
      end
    endcase
  end

  always_comb begin
    u_sum = sadd(u_reg, sneg(mul_res));
    umag  = UMAG_W'(u_reg[SW-1] ? -u_reg : u_reg);
    pprod = PPROD_W'(umag) * PPROD_W'(hlmc_pkg::PERCENT);
    qprod = QPROD_W'(pct) * QPROD_W'(hlmc_pkg::DIV_RECIP);
    quo   = qprod[hlmc_pkg::DIV_SHIFT +: hlmc_pkg::QUO_W];
    u_pos = !u_reg[SW-1] && (u_reg != '0);
  end

  hlmc_qmul #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_qmul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .operand (mul_a),
    .done    (mul_done),
    .result  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= OP_KP;
      m_tvalid <= 1'b0;
      est_err  <= '0;
      est_rate <= '0;
      kp       <= hlmc_pkg::RST_POS_GAIN;
      kv       <= hlmc_pkg::RST_RATE_GAIN;
      kep      <= hlmc_pkg::RST_OBS_EGAIN;
      kef      <= hlmc_pkg::RST_OBS_RGAIN;
      jinv     <= hlmc_pkg::RST_INV_INERT;
      period   <= hlmc_pkg::RST_PERIOD;
      deadband <= hlmc_pkg::RST_DEADBAND;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_POS_GAIN:  kp       <= cfg_data;
          CFG_RATE_GAIN: kv       <= cfg_data;
          CFG_OBS_EGAIN: kep      <= cfg_data;
          CFG_OBS_RGAIN: kef      <= cfg_data;
          CFG_INV_INERT: jinv     <= cfg_data;
          CFG_PERIOD:    period   <= cfg_data[hlmc_pkg::PERIOD_W-1:0];
          CFG_DEADBAND:  deadband <= cfg_data[hlmc_pkg::DB_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            hd_meas <= s_tdata[hlmc_pkg::HEAD_W-1:0];
            hd_tgt  <= s_tdata[hlmc_pkg::HEAD_W +: hlmc_pkg::TGT_W];
            trk     <= s_tuser[0];
            state   <= S_ERR;
          end
        end
        S_ERR: begin
          if (in_db) begin
            // zero drive, observer left alone
            r_drive <= '0;
            r_db    <= 1'b1;
            r_sat   <= 1'b0;
            state   <= S_OUT;
          end else begin
            err_e    <= e_sat;
            op       <= OP_KP;
            sat_flag <= 1'b0;
            state    <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            state <= S_ISSUE;
            case (op)
              OP_KP: begin
                u_reg <= sneg(mul_res);
                op    <= OP_KV;
              end
              OP_KV: begin
                if (u_sum > LIM) begin
                  u_reg    <= LIM;
                  sat_flag <= 1'b1;
                end else if (u_sum < NLIM) begin
                  u_reg    <= NLIM;
                  sat_flag <= 1'b1;
                end else begin
                  u_reg <= u_sum;
                end
                op <= OP_EKT;
              end
              OP_EKT: begin
                ekt <= mul_res[GW-1:0];
                op  <= OP_FKT;
              end
              OP_FKT: begin
                fkt <= mul_res[GW-1:0];
                op  <= OP_WT;
              end
              OP_WT: begin
                tmp <= mul_res;
                op  <= OP_EINNOV;
              end
              OP_EINNOV: begin
                newe <= sadd(tmp, mul_res);
                op   <= OP_UT;
              end
              OP_UT: begin
                tmp <= mul_res;
                op  <= OP_UJ;
              end
              OP_UJ: begin
                tmp <= mul_res;
                op  <= OP_WINNOV;
              end
              OP_WINNOV: begin
                // commit both observer states together
                est_rate <= sadd(tmp, mul_res);
                est_err  <= newe;
                state    <= S_SCALE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCALE: begin
          pct   <= pprod[FB +: hlmc_pkg::PCT_W];
          state <= S_DIV;
        end
        S_DIV: begin
          r_drive <= u_pos ? -hlmc_pkg::DRIVE_W'(quo) : hlmc_pkg::DRIVE_W'(quo);
          r_db    <= 1'b0;
          r_sat   <= sat_flag;
          state   <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= r_drive;
            m_tuser  <= {r_sat, r_db};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HLMC_ASSERT_IMP(a_db_zero, m_tvalid && m_tuser[0], m_tdata == '0 && !m_tuser[1], "deadband item with drive")
  `HLMC_ASSERT_IMP(a_drive_range, m_tvalid, $signed(m_tdata) <= 8'sd100 && $signed(m_tdata) >= -8'sd100, "drive out of range")
  `HLMC_ASSERT_IMP(a_mul_wait, mul_done, state == S_WAIT, "multiply result with no waiting step")
  `HLMC_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state == S_ERR && !s_tready, "ready after accept")

endmodule

// File: rtl/hlmc_qmul.sv
// Saturating signed-by-unsigned gain multiply, (a * g) >> 16 truncated toward zero.
// The magnitude is consumed one chunk per cycle, top chunk first.
module hlmc_qmul #(
  parameter int STATE_WIDTH = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hlmc_pkg::mul_req_t            req,
  input  logic signed [STATE_WIDTH-1:0] operand,
  output logic                          done,
  output logic signed [STATE_WIDTH-1:0] result
);

  localparam int CW    = hlmc_pkg::CHUNK_W;
  localparam int GW    = hlmc_pkg::GAIN_W;
  localparam int NCH   = (STATE_WIDTH + CW - 1) / CW;
  localparam int MW    = NCH * CW;
  localparam int AW    = MW + GW;
  localparam int RW    = AW - hlmc_pkg::GAIN_FRAC;
  localparam int CNT_W = $clog2(NCH + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCH);
  localparam logic [RW-1:0] CAP_POS = RW'({(STATE_WIDTH-1){1'b1}});
  // At full host word width the negative limit stops one short of the minimum
  localparam logic [RW-1:0] CAP_NEG =
    (STATE_WIDTH >= hlmc_pkg::HOST_WORD_W) ? CAP_POS : CAP_POS + 1'b1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [MW-1:0]    mag;
  logic [GW-1:0]    gain;
  logic [AW-1:0]    acc;

  logic [STATE_WIDTH-1:0] abs_a;
  logic [CW+GW-1:0]       part;
  logic [RW-1:0]          res_mag;
  logic [RW-1:0]          sat_mag;
  logic [STATE_WIDTH-1:0] res_out;

  always_comb begin
    abs_a   = operand[STATE_WIDTH-1] ? STATE_WIDTH'(-operand) : STATE_WIDTH'(operand);
    part    = mag[MW-1 -: CW] * gain;
    res_mag = acc[AW-1:hlmc_pkg::GAIN_FRAC];
    if (neg) begin
      sat_mag = (res_mag > CAP_NEG) ? CAP_NEG : res_mag;
      res_out = -STATE_WIDTH'(sat_mag);
    end else begin
      sat_mag = (res_mag > CAP_POS) ? CAP_POS : res_mag;
      res_out = STATE_WIDTH'(sat_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= operand[STATE_WIDTH-1];
        mag  <= MW'(abs_a);
        gain <= req.gain;
        acc  <= '0;
      end else if (busy) begin
        if (cnt != CNT_LAST) begin
          // shift in the next partial product
          acc <= (acc << CW) + AW'(part);
          mag <= mag << CW;
          cnt <= cnt + 1'b1;
        end else begin
          result <= $signed(res_out);
          done   <= 1'b1;
          busy   <= 1'b0;
        end
      end
    end
  end

endmodule

// File: dv/tb_heading_lqg_motor_control_core.sv
`timescale 1ns / 1ps

module tb_heading_lqg_motor_control_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hlmc_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int STATE_W      = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 60;
  localparam longint TURN_UNITS = longint'(FULL_TURN) * 128;
  localparam longint STATE_MAX  = (longint'(1) << (STATE_W - 1)) - 1;
  localparam longint STATE_MIN  = -STATE_MAX - 1;
  localparam logic [STATE_W+31:0] STATE_SPAN = (STATE_W + 32)'(1) << (STATE_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_GAIN, REG_RATE_GAIN, REG_OBS_EGAIN, REG_OBS_RGAIN,
    REG_INV_INERT, REG_PERIOD, REG_DEADBAND, REG_SPARE
  } cfg_reg_e;

  typedef struct packed {
    logic [HEAD_W-1:0] measured;
    logic [TGT_W-1:0]  target;
    logic              track;
  } heading_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               in_db;
    logic               sat;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DRIVE_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  // register copies and observer state of the predictor
  logic [GAIN_W-1:0]   pos_gain   = RST_POS_GAIN;
  logic [GAIN_W-1:0]   rate_gain  = RST_RATE_GAIN;
  logic [GAIN_W-1:0]   obs_egain  = RST_OBS_EGAIN;
  logic [GAIN_W-1:0]   obs_rgain  = RST_OBS_RGAIN;
  logic [GAIN_W-1:0]   inv_inert  = RST_INV_INERT;
  logic [PERIOD_W-1:0] period     = RST_PERIOD;
  logic [DB_W-1:0]     deadband   = RST_DEADBAND;
  longint est_err  = 0;
  longint est_rate = 0;

  drive_result_t pending_drive_q[$];
  int mismatches = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int deadband_seen = 0;
  int clamped_seen = 0;
  int settings_used = 1;
  bit steady = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  heading_lqg_motor_control_core #(
    .FRAC_BITS(FRAC_BITS),
    .STATE_WIDTH(STATE_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint sat_state(longint v);
    if (v > STATE_MAX) return STATE_MAX;
    if (v < STATE_MIN) return STATE_MIN;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // signed state times unsigned Q16 gain, truncated toward zero, saturated
  function automatic longint gain_mul(longint a, logic [31:0] g);
    logic [STATE_W-1:0]  a_mag;
    logic [STATE_W+31:0] prod;
    logic [STATE_W+31:0] q;
    a_mag = (a < 0) ? STATE_W'(-a) : STATE_W'(a);
    prod = a_mag * g;
    q = prod >> GAIN_FRAC;
    if (q >= STATE_SPAN) return (a < 0) ? STATE_MIN : STATE_MAX;
    return (a < 0) ? -longint'(q[STATE_W-1:0]) : longint'(q[STATE_W-1:0]);
  endfunction

  // one control tick: expected drive, and advance the observer when it runs
  function automatic drive_result_t predict_drive(heading_item_t it);
    longint meas, setp, e1, e2, e3, err, e, u, lim, new_err, new_rate, pct;
    logic [31:0] ekt, fkt;
    bit clamp;
    meas = longint'(it.measured);
    setp = it.track ? longint'(it.target) * 128 : meas;
    e1 = setp - meas;
    e2 = setp + TURN_UNITS - meas;
    e3 = setp - meas - TURN_UNITS;
    if (mag(e1) <= mag(e2) && mag(e1) <= mag(e3)) err = e1;
    else if (mag(e2) <= mag(e1) && mag(e2) <= mag(e3)) err = e2;
    else err = e3;
    if (mag(err) < longint'(deadband)) return '{drive: '0, in_db: 1'b1, sat: 1'b0};

    e = sat_state(err * (longint'(1) << (FRAC_BITS - HEAD_FRAC)));
    u = sat_state(sat_state(-gain_mul(e, pos_gain)) + sat_state(-gain_mul(est_rate, rate_gain)));
    lim = longint'(U_LIMIT) << FRAC_BITS;
    clamp = 1'b0;
    if (u > lim) begin
      u = lim;
      clamp = 1'b1;
    end else if (u < -lim) begin
      u = -lim;
      clamp = 1'b1;
    end

    ekt = 32'((longint'(obs_egain) * longint'(period)) >> GAIN_FRAC);
    fkt = 32'((longint'(obs_rgain) * longint'(period)) >> GAIN_FRAC);
    new_err = sat_state(gain_mul(est_rate, period) +
                        gain_mul(sat_state(e + sat_state(-est_err)), ekt));
    new_rate = sat_state(gain_mul(gain_mul(u, period), inv_inert) +
                         gain_mul(sat_state(e + sat_state(-new_err)), fkt));
    est_err = new_err;
    est_rate = new_rate;

    pct = (mag(u) * PERCENT) / lim;
    if (u > 0) pct = -pct;
    return '{drive: DRIVE_W'(pct), in_db: 1'b0, sat: clamp};
  endfunction

  function automatic heading_item_t tick(int m, int t, bit tr);
    return '{measured: HEAD_W'(m), target: TGT_W'(t), track: tr};
  endfunction

  function automatic int wrap_heading(int h);
    int w;
    w = h % int'(TURN_UNITS);
    return (w < 0) ? w + int'(TURN_UNITS) : w;
  endfunction

  function automatic heading_item_t random_item();
    heading_item_t it;
    int pick, span;
    pick = $urandom_range(99);
    it.track = 1'b1;
    it.target = TGT_W'($urandom_range(0, FULL_TURN - 1));
    if (pick < 60) begin
      span = (pick < 30) ? 2000 : 23040;
      it.measured = HEAD_W'(wrap_heading(int'(it.target) * 128 +
                                         int'($urandom_range(0, 2 * span)) - span));
    end else if (pick < 75) begin
      it.track = 1'b0;
      it.measured = HEAD_W'($urandom_range(0, TURN_UNITS - 1));
    end else if (pick < 90) begin
      it.measured = HEAD_W'($urandom());
      it.target = TGT_W'($urandom());
      it.track = 1'($urandom());
    end else begin
      // straddle the north seam
      it.target = $urandom_range(1) ? TGT_W'(0) : TGT_W'(FULL_TURN - 1);
      it.measured = $urandom_range(1) ? HEAD_W'($urandom_range(0, 200))
                                      : HEAD_W'($urandom_range(45880, TURN_UNITS - 1));
    end
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    return GAIN_W'($urandom() >> $urandom_range(8, 24));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_tick(heading_item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 8) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = S_TDATA_W'({it.target, it.measured});
    s_tuser = it.track;
    do @(posedge clk); while (!s_tready);
    pending_drive_q.push_back(predict_drive(it));
    ticks_sent++;
  endtask

  task automatic send_random(int n);
    repeat (n) send_tick(random_item());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [GAIN_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POS_GAIN:  pos_gain = data;
      REG_RATE_GAIN: rate_gain = data;
      REG_OBS_EGAIN: obs_egain = data;
      REG_OBS_RGAIN: obs_rgain = data;
      REG_INV_INERT: inv_inert = data;
      REG_PERIOD:    period = data[PERIOD_W-1:0];
      REG_DEADBAND:  deadband = data[DB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(logic [GAIN_W-1:0] kp, kv, keg, krg, jinv, per, db);
    wait_drained();
    write_reg(REG_POS_GAIN, kp);
    write_reg(REG_RATE_GAIN, kv);
    write_reg(REG_OBS_EGAIN, keg);
    write_reg(REG_OBS_RGAIN, krg);
    write_reg(REG_INV_INERT, jinv);
    write_reg(REG_PERIOD, per);
    write_reg(REG_DEADBAND, db);
    settings_used++;
  endtask

  // reset gains: seam ties, deadband edges, clamping both ways, out-of-range headings
  task automatic test_directed();
    send_tick(tick(0, 0, 1));
    send_tick(tick(0, 359, 1));
    send_tick(tick(46079, 0, 1));
    send_tick(tick(23040, 0, 1));
    send_tick(tick(0, 180, 1));
    send_tick(tick(1217, 10, 1));
    send_tick(tick(1216, 10, 1));
    send_tick(tick(1344, 10, 1));
    send_tick(tick(12345, 0, 0));
    send_tick(tick(65535, 0, 0));
    send_tick(tick(65535, 511, 1));
    send_tick(tick(65535, 0, 1));
    send_tick(tick(0, 511, 1));
    send_tick(tick(46079, 359, 1));
    send_tick(tick(46079, 511, 1));
    // small errors keep the effort below the clamp and walk the observer
    send_tick(tick(90 * 128 - 640, 90, 1));
    send_tick(tick(90 * 128 - 400, 90, 1));
    send_tick(tick(90 * 128 - 200, 90, 1));
    send_tick(tick(90 * 128 + 100, 90, 1));
    send_tick(tick(90 * 128 + 300, 90, 1));
    send_tick(tick(90 * 128 - 30, 90, 1));
    send_tick(tick(90 * 128 + 900, 90, 1));
  endtask

  task automatic test_register_extremes();
    // zero deadband runs the loop even with tracking off
    apply_setting('0, '0, '0, '0, '0, '0, '0);
    send_random(25);
    apply_setting('1, '1, '1, '1, '1, '1, '0);
    send_random(25);
    apply_setting(RST_POS_GAIN, RST_RATE_GAIN, RST_OBS_EGAIN, RST_OBS_RGAIN,
                  RST_INV_INERT, RST_PERIOD, '1);
    send_random(15);
    wait_drained();
    write_reg(REG_SPARE, GAIN_W'($urandom()));
    send_random(10);
    repeat (4) begin
      apply_setting(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                    GAIN_W'($urandom() >> $urandom_range(16, 28)),
                    GAIN_W'($urandom_range(0, 512)));
      send_random(25);
    end
    apply_setting(RST_POS_GAIN, RST_RATE_GAIN, RST_OBS_EGAIN, RST_OBS_RGAIN,
                  RST_INV_INERT, RST_PERIOD, RST_DEADBAND);
  endtask

  // heading closes in on the target within each run, starting from a fresh offset
  task automatic test_closing_runs();
    int tgt, offset;
    for (int run = 0; run < 16; run++) begin
      steady = (run < 6);
      tgt = $urandom_range(0, FULL_TURN - 1);
      offset = int'($urandom_range(0, 2 * 23040)) - 23040;
      repeat (12) begin
        send_tick(tick(wrap_heading(tgt * 128 - offset), tgt, 1));
        offset = offset * int'($urandom_range(55, 90)) / 100 + int'($urandom_range(0, 20)) - 10;
      end
    end
    steady = 1'b0;
    send_random(40);
  endtask

  task automatic test_output_backpressure();
    hold_req++;
    send_random(8);
  endtask

  task automatic test_drain_pause();
    send_random(10);
    wait_drained();
    send_random(10);
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = steady || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser[0]) deadband_seen++;
      if (m_tuser[1]) clamped_seen++;
      if (pending_drive_q.size() == 0) begin
        report_mismatch("result with nothing pending", $signed(m_tdata), 0);
      end else begin
        want = pending_drive_q.pop_front();
        if (m_tdata !== want.drive)
          report_mismatch("drive_percent", $signed(m_tdata), $signed(want.drive));
        if (m_tuser[0] !== want.in_db)
          report_mismatch("in_deadband", m_tuser[0], want.in_db);
        if (m_tuser[1] !== want.sat)
          report_mismatch("saturated", m_tuser[1], want.sat);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : main
    int waited;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_register_extremes();
    test_closing_runs();
    test_output_backpressure();
    test_drain_pause();

    @(negedge clk);
    s_tvalid = 1'b0;
    waited = 0;
    while (pending_drive_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_drive_q.size() != 0)
      report_mismatch("results never delivered", pending_drive_q.size(), 0);

    $display("ran %0d ticks under %0d register settings, %0d results checked",
             ticks_sent, settings_used, results_seen);
    $display("%0d results in the deadband, %0d with clamped effort",
             deadband_seen, clamped_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
